// File: rtl/rle_pkg.sv
// Shared types and constants of the escape-byte run-length encoder.
// Used by every module under rtl/; depends on nothing.
package rle_pkg;

   localparam int MAX_BLOCK_BYTES_DEFAULT = 65536;

   localparam logic [7:0] ESC_BYTE      = 8'hFF;
   localparam logic [7:0] RUN_MAX       = 8'd255;
   localparam logic [7:0] RUN_MIN_TOKEN = 8'd3;

   // Largest number of encoded bytes one raw byte can cause.
   localparam int MAX_BURST = 6;
   localparam int BURST_W   = $clog2(MAX_BURST + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       block_end;
   } rle_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       smaller;
   } rle_rsp_type;

   typedef struct packed {
      logic [BURST_W-1:0]                count;
      rle_rsp_type [MAX_BURST-1:0]       entry;
   } rle_burst_type;

endpackage

// File: rtl/rle_run_tracker.sv
// Run state, byte counters and encoded-burst generation for one raw byte.
// Depends on rle_pkg.
module rle_run_tracker import rle_pkg::*; #(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  rle_req_type   item,
   input  logic          fire,
   output rle_burst_type burst
);

   localparam int IN_W  = $clog2(MAX_BLOCK_BYTES + 1);
   localparam int OUT_W = $clog2(3 * MAX_BLOCK_BYTES + 1);
   localparam logic [IN_W-1:0]  IN_LIMIT  = IN_W'(MAX_BLOCK_BYTES);
   localparam logic [OUT_W-1:0] OUT_LIMIT = OUT_W'(3 * MAX_BLOCK_BYTES);

   logic [7:0]       run_value_ff, run_value_in;
   logic [7:0]       run_count_ff, run_count_in;
   logic [IN_W-1:0]  bytes_in_ff, bytes_in_in;
   logic [OUT_W-1:0] bytes_out_ff, bytes_out_in;

   logic             extend;
   logic [1:0]       n_old, n_end;
   logic [2:0]       n_total;
   logic [7:0]       old_bytes [4];
   logic [7:0]       end_bytes [4];
   logic [OUT_W:0]   out_sum;

   // Number of bytes a run flushes to: none, one or two literals, or a token.
   function automatic logic [1:0] flush_len(input logic [7:0] value,
                                            input logic [7:0] count);
      logic [1:0] len;
      if (count == 8'd0)
         len = 2'd0;
      else if (count >= RUN_MIN_TOKEN || value == ESC_BYTE)
         len = 2'd3;
      else
         len = count[1:0];
      return len;
   endfunction

   function automatic logic [7:0] flush_byte(input logic [7:0] value,
                                             input logic [7:0] count,
                                             input logic [1:0] idx);
      logic       token;
      logic [7:0] b;
      token = (count >= RUN_MIN_TOKEN) || (value == ESC_BYTE);
      b = value;
      if (token && idx == 2'd0)
         b = ESC_BYTE;
      else if (token && idx == 2'd1)
         b = count;
      return b;
   endfunction

   always_comb begin
      extend = (run_count_ff != 8'd0) && (item.data_byte == run_value_ff)
               && (run_count_ff != RUN_MAX);
      n_old = extend ? 2'd0 : flush_len(run_value_ff, run_count_ff);

      run_value_in = item.data_byte;
      run_count_in = extend ? run_count_ff + 8'd1 : 8'd1;

      n_end   = item.block_end ? flush_len(run_value_in, run_count_in) : 2'd0;
      n_total = {1'b0, n_old} + {1'b0, n_end};

      for (int k = 0; k < 4; k++) begin
         old_bytes[k] = flush_byte(run_value_ff, run_count_ff, 2'(k));
         end_bytes[k] = flush_byte(run_value_in, run_count_in, 2'(k));
      end

      bytes_in_in = (bytes_in_ff == IN_LIMIT) ? bytes_in_ff : bytes_in_ff + 1'b1;
      out_sum     = (OUT_W+1)'(bytes_out_ff) + (OUT_W+1)'(n_total);
      bytes_out_in = (out_sum > {1'b0, OUT_LIMIT}) ? OUT_LIMIT : out_sum[OUT_W-1:0];
   end

   // Lay out old-run bytes first, then the end-of-block flush.
   always_comb begin
      burst.count = BURST_W'(n_total);
      for (int i = 0; i < MAX_BURST; i++) begin : lay
         logic [2:0] pos;
         pos = 3'(i) - {1'b0, n_old};
         burst.entry[i] = '0;
         if (3'(i) < {1'b0, n_old})
            burst.entry[i].out_byte = old_bytes[2'(i)];
         else if (3'(i) < n_total)
            burst.entry[i].out_byte = end_bytes[pos[1:0]];
         if (item.block_end && 3'(i) == n_total - 3'd1) begin
            burst.entry[i].out_last = 1'b1;
            burst.entry[i].smaller  = bytes_out_in < OUT_W'(bytes_in_in);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && item.block_end)) begin
         run_value_ff <= '0;
         run_count_ff <= '0;
         bytes_in_ff  <= '0;
         bytes_out_ff <= '0;
      end else if (fire) begin
         run_value_ff <= run_value_in;
         run_count_ff <= run_count_in;
         bytes_in_ff  <= bytes_in_in;
         bytes_out_ff <= bytes_out_in;
      end
   end

endmodule

// File: rtl/rle_burst_queue.sv
// Result register: holds the encoded bytes of one raw byte and shifts them out.
// Depends on rle_pkg.
module rle_burst_queue import rle_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          load,
   input  rle_burst_type burst,
   input  logic          take,
   output logic          free,
   output logic          rsp_valid,
   output rle_rsp_type   rsp_data
);

   rle_rsp_type [MAX_BURST-1:0] entry_ff;
   logic [BURST_W-1:0]          count_ff;

   assign rsp_valid = count_ff != '0;
   assign rsp_data  = entry_ff[0];
   // Room for a new burst when empty, or once the last held byte leaves this cycle.
   assign free = (count_ff == '0) || (count_ff == BURST_W'(1) && take);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= burst.count;
      end else if (take) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         entry_ff <= burst.entry;
      end else if (take) begin
         for (int i = 0; i < MAX_BURST - 1; i++)
            entry_ff[i] <= entry_ff[i+1];
      end
   end

endmodule

// File: rtl/rle_escape_byte_encoder.sv
// Top level of the escape-byte run-length encoder.
// Depends on rle_pkg, rle_run_tracker and rle_burst_queue.
//
// Usage:
//   Raw bytes enter on the req_ channel, one transfer per byte, with
//   block_end set on the final byte of a block. Encoded bytes leave on the
//   rsp_ channel, one transfer per byte. Runs of three or more equal bytes,
//   and any run of 0xFF, leave as the token 0xFF, length, byte; shorter runs
//   leave as literal bytes. The final encoded byte of a block carries
//   out_last, and with it smaller, set when the encoded block is shorter
//   than the raw one (counts saturate at the block size and three times it).
// Path: a raw byte is held in the input register; when it advances, its
//   encoded bytes, if any, load into the result register, which offers
//   the first result byte on rsp_.
// Throughput: one raw byte per cycle while bytes extend a run. A byte that
//   closes a run or a block makes up to six result bytes; these drain at
//   one per cycle from the result register unless rsp_ stalls; the next
//   byte that itself makes results waits until the last of them transfers.
// Reset: clears the run, both counters and both registers; req_stall is low
//   from the first cycle after reset. A stalled rsp_ holds its byte, and
//   req_stall rises once the input register cannot hand its byte on.
module rle_escape_byte_encoder import rle_pkg::*; #(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rle_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rle_rsp_type rsp_data
);

   rle_req_type   req_ff;
   logic          req_valid_ff;
   rle_burst_type burst;
   logic          queue_free;
   logic          advance;
   logic          rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Advance the held byte when it makes no results, or the queue has room.
   assign advance   = req_valid_ff && (burst.count == '0 || queue_free);
   assign req_stall = req_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   rle_run_tracker #(
      .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
   ) u_tracker (
      .clock (clock),
      .reset (reset),
      .item  (req_ff),
      .fire  (advance),
      .burst (burst)
   );

   // Load only bursts that hold bytes; empty ones leave the queue draining.
   rle_burst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && burst.count != '0),
      .burst     (burst),
      .take      (rsp_take),
      .free      (queue_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/rle_checker.sv
// Port-level checks of the escape-byte run-length encoder, bound to its top.
// Depends on rle_pkg and rle_escape_byte_encoder.
module rle_port_checker import rle_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input rle_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input rle_rsp_type rsp_data
);

   // A stalled result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A stalled request stays offered with the same byte.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("request changed while stalled");

   // smaller only means something on the final byte of a block.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_last |-> !rsp_data.smaller)
      else $error("smaller set without out_last");

   // Nothing is offered right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // The input side is open right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("req_stall high right after reset");

endmodule

bind rle_escape_byte_encoder rle_port_checker u_rle_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/sv/rle_checker.sv
// Scoreboard for the escape-byte run-length encoder: watches both channels,
// predicts the encoded stream and compares it transfer by transfer.
// Depends on rle_pkg for the channel types and the encoding constants.
module rle_checker import rle_pkg::*; #(
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  rle_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rle_rsp_type rsp_data,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RAW_CAP   = MAX_BLOCK_BYTES;
   localparam int CODED_CAP = 3 * MAX_BLOCK_BYTES;
   localparam int RAW_W     = $clog2(RAW_CAP + 1);
   localparam int CODED_W   = $clog2(CODED_CAP + 1);

   logic [7:0]         run_byte;
   logic [7:0]         run_len;
   logic [RAW_W-1:0]   raw_count;
   logic [CODED_W-1:0] coded_count;

   rle_rsp_type coded_q[$];
   rle_rsp_type burst[MAX_BURST];
   int          burst_n;

   function automatic void clear_block();
      run_byte    = '0;
      run_len     = '0;
      raw_count   = '0;
      coded_count = '0;
   endfunction

   function automatic void put_coded(logic [7:0] b);
      burst[burst_n] = '{out_byte: b, out_last: 1'b0, smaller: 1'b0};
      burst_n++;
      if (coded_count < CODED_CAP)
         coded_count++;
   endfunction

   // Emit the pending run as a token or as literals, then drop it.
   function automatic void close_run();
      if (run_len == 0)
         return;
      if (run_len >= RUN_MIN_TOKEN || run_byte == ESC_BYTE) begin
         put_coded(ESC_BYTE);
         put_coded(run_len);
         put_coded(run_byte);
      end else begin
         for (int i = 0; i < int'(run_len); i++)
            put_coded(run_byte);
      end
      run_len = '0;
   endfunction

   function automatic void encode_byte(rle_req_type item);
      burst_n = 0;
      if (raw_count < RAW_CAP)
         raw_count++;
      if (run_len != 0 && item.data_byte == run_byte && run_len < RUN_MAX) begin
         run_len++;
      end else begin
         close_run();
         run_byte = item.data_byte;
         run_len  = 8'd1;
      end
      if (item.block_end) begin
         close_run();
         burst[burst_n-1].out_last = 1'b1;
         burst[burst_n-1].smaller  = (coded_count < raw_count);
         clear_block();
      end
      for (int i = 0; i < burst_n; i++)
         coded_q.insert(coded_q.size(), burst[i]);
   endfunction

   function automatic void report(string field, logic [7:0] want, logic [7:0] got);
      fail_count++;
      $display("%0t rle_checker: %s expected %02h actual %02h", $time, field, want, got);
   endfunction

   function automatic void check_coded(rle_rsp_type got);
      rle_rsp_type want;
      if (coded_q.size() == 0) begin
         fail_count++;
         $display("%0t rle_checker: unexpected byte, expected none actual %02h/%b/%b",
                  $time, got.out_byte, got.out_last, got.smaller);
         return;
      end
      want = coded_q.pop_front();
      if (got.out_byte !== want.out_byte)
         report("out_byte", want.out_byte, got.out_byte);
      if (got.out_last !== want.out_last)
         report("out_last", 8'(want.out_last), 8'(got.out_last));
      if (got.smaller !== want.smaller)
         report("smaller", 8'(want.smaller), 8'(got.smaller));
   endfunction

   // Check the result first: its expectation always comes from an older transfer.
   always @(posedge clock) begin
      if (reset) begin
         clear_block();
         coded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_coded(rsp_data);
         if (req_valid && !req_stall)
            encode_byte(req_data);
      end
      pending = coded_q.size();
   end

endmodule

// File: tb/sv/tb.sv
// Top of the encoder testbench: clock, reset, byte stimulus and verdict.
// Depends on rle_pkg, rle_escape_byte_encoder and rle_checker.
module tb import rle_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Block size of the encoder under test.
   localparam int BLOCK_BYTES   = 512;
   localparam int RANDOM_ITEMS  = 180;
   localparam int QUIET_AFTER   = 150;
   localparam int SQUEEZE_LEN   = 90;
   localparam int DRAIN_CYCLES  = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   rle_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rle_rsp_type rsp_data;
   int          fail_count;
   int          pending;

   // Handshake between stimulus and the receiver process.
   logic quiet;
   logic squeeze;
   logic squeeze_done;
   int   rand_items;

   rle_escape_byte_encoder #(.MAX_BLOCK_BYTES(BLOCK_BYTES)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   rle_checker #(.MAX_BLOCK_BYTES(BLOCK_BYTES)) u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop if the run never finishes.
   initial begin
      #12_000_000;
      $display("tb: failure");
      $finish;
   end

   // Offer one raw byte and hold it until the transfer completes. A random
   // idle burst may come first, unless the run has gone quiet.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, block_end: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Send len copies of b; mark block end on the final copy if asked.
   task automatic send_run(input logic [7:0] b, input int len, input logic end_block);
      for (int i = 0; i < len; i++)
         send_byte(b, end_block && (i == len - 1));
   endtask

   // Receiver: random stall bursts, free stretches, and one long hold-off
   // that makes the encoder fill up and push back on its input.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !squeeze_done) begin
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_LEN) @(posedge clock);
            rsp_stall <= 1'b0;
            squeeze_done = 1'b1;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(20, 60)) @(posedge clock);
         end
      end
   end

   initial begin
      logic [7:0] run_b;
      int         run_n;
      int         pick;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      quiet        = 1'b0;
      squeeze      = 1'b0;
      squeeze_done = 1'b0;
      rand_items   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed blocks: one-byte blocks, a lone escape byte, a two-byte
      // literal run, a minimal token, a run broken by a new byte, a short
      // escape run, a block end that both closes a token and flushes an
      // escape token, and a block of two different single bytes.
      send_run(8'h00, 1, 1'b1);
      send_run(8'hFF, 1, 1'b1);
      send_run(8'hAB, 2, 1'b1);
      send_run(8'h5A, 3, 1'b1);
      send_run(8'h5A, 4, 1'b0);
      send_run(8'h01, 1, 1'b1);
      send_run(8'hFF, 2, 1'b0);
      send_run(8'h00, 1, 1'b1);
      send_run(8'h33, 3, 1'b0);
      send_run(8'hFF, 1, 1'b1);
      send_run(8'h80, 1, 1'b0);
      send_run(8'h7F, 1, 1'b1);

      // Run at its limit: a byte equal to a full run starts a fresh one, and
      // the block end then flushes two tokens (six bytes from one transfer).
      send_run(8'hFF, 256, 1'b1);

      // Random runs with random content; request the long hold-off now so
      // it lands while bytes keep coming.
      squeeze = 1'b1;
      while (rand_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 3);
         if (pick == 0)
            run_b = ESC_BYTE;
         else if (pick == 1)
            run_b = 8'h00;
         else
            run_b = 8'($urandom);
         pick = $urandom_range(0, 59);
         if (pick == 0)
            run_n = $urandom_range(20, 40);
         else if (pick < 8)
            run_n = $urandom_range(3, 8);
         else
            run_n = $urandom_range(1, 3);
         if (run_n > RANDOM_ITEMS - rand_items)
            run_n = RANDOM_ITEMS - rand_items;
         for (int i = 0; i < run_n; i++) begin
            send_byte(run_b, ($urandom_range(0, 19) == 0) ||
                             (i == run_n - 1 && $urandom_range(0, 5) == 0));
            rand_items++;
            if (rand_items >= QUIET_AFTER)
               quiet = 1'b1;
         end
      end
      // Close the last block so its pending run comes out.
      send_byte(8'($urandom), 1'b1);
      req_valid <= 1'b0;

      // Drain: wait on the scoreboard, then wait out DRAIN_CYCLES for stray bytes.
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
